/* rtl/dht_pkg.sv */
// Shared types and codes for the double hashing table unit.
package dht_pkg;

    localparam int KEY_BITS    = 31;
    localparam int DATA_BITS   = 32;
    localparam int STATUS_BITS = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic                 operation;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [DATA_BITS-1:0]   found_value;
    } t_out_item;

endpackage

/* rtl/double_hash_table_unit.sv */
// Top level of the double hashing key/value table unit.
// The front reduces the key to its home slot and probe step, then hands the transaction to
// the work queue; the back reads and checks one slot per probe and offers the result. An
// insert refused on a full table skips the probes. The front takes a new key only when idle
// and the back works on one transaction at a time; the work queue lets the front reduce the
// next key while the back probes, so the back sets the pace for long probe chains.
// Reset is synchronous and active low; afterwards a clearing pass writes every slot, during
// which full stays high.
module double_hash_table_unit #(
    parameter int SLOT_COUNT = 101,
    parameter int STEP_PRIME = 97,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dht_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output dht_pkg::t_out_item o_result
);

    import dht_pkg::*;

    localparam int HW = $clog2(SLOT_COUNT);
    localparam int WW = $bits(t_in_item) + 2 * HW;
    localparam int OW = $bits(t_out_item);

    // Front end signals: a transaction with its home slot and probe step.
    logic          f_ready;
    logic          f_valid;
    t_in_item      f_item;
    logic [HW-1:0] f_home;
    logic [HW-1:0] f_step;

    // Work queue between front and back.
    logic          wq_full;
    logic          wq_empty;
    logic [WW-1:0] wq_rdata;
    logic          wq_pop;
    t_in_item      b_item;
    logic [HW-1:0] b_home;
    logic [HW-1:0] b_step;

    // Result path.
    logic          b_rvalid;
    t_out_item     b_result;
    logic          rq_full;
    logic [OW-1:0] rq_rdata;
    logic          clearing;

    // No transaction is taken while the slot store is being cleared.
    assign full = !f_ready || clearing;

    dht_front #(
        .SLOT_COUNT (SLOT_COUNT),
        .STEP_PRIME (STEP_PRIME)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push && !clearing),
        .i_item  (i_item),
        .o_ready (f_ready),
        .o_valid (f_valid),
        .o_item  (f_item),
        .o_home  (f_home),
        .o_step  (f_step),
        .i_ready (!wq_full)
    );

    // The two-entry queue lets the front reduce the next key while the back probes.
    dht_queue #(
        .WIDTH (WW),
        .DEPTH (2)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_item, f_home, f_step}),
        .o_full  (wq_full),
        .i_pop   (wq_pop),
        .o_data  (wq_rdata),
        .o_empty (wq_empty)
    );

    assign b_item = t_in_item'(wq_rdata[WW-1 -: $bits(t_in_item)]);
    assign b_home = wq_rdata[2*HW-1 -: HW];
    assign b_step = wq_rdata[HW-1:0];

    dht_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qvalid   (!wq_empty),
        .o_qpop     (wq_pop),
        .i_item     (b_item),
        .i_home     (b_home),
        .i_step     (b_step),
        .o_rvalid   (b_rvalid),
        .o_result   (b_result),
        .i_rready   (!rq_full),
        .o_clearing (clearing)
    );

    // Finished results wait here, so the back can take the next transaction.
    dht_queue #(
        .WIDTH (OW),
        .DEPTH (2)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_rvalid),
        .i_data  (b_result),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_rdata),
        .o_empty (empty)
    );

    assign o_result = t_out_item'(rq_rdata);

endmodule

/* rtl/dht_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dht_queue.sv */
// Small register FIFO used between the front and back and on the result side.
module dht_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* rtl/dht_front.sv */
// Front end: accepts a transaction and computes its home slot and probe step.
module dht_front #(
    parameter int SLOT_COUNT = 101,
    parameter int STEP_PRIME = 97
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dht_pkg::t_in_item             i_item,
    output logic                          o_ready,
    output logic                          o_valid,
    output dht_pkg::t_in_item             o_item,
    output logic [$clog2(SLOT_COUNT)-1:0] o_home,
    output logic [$clog2(SLOT_COUNT)-1:0] o_step,
    input  logic                          i_ready
);

    import dht_pkg::*;

    localparam int HW   = $clog2(SLOT_COUNT);
    localparam int PW   = $clog2(STEP_PRIME);
    localparam int SW   = $clog2(STEP_PRIME + 1);
    localparam int SDIG = (SW + 3) / 4;
    localparam int SDW  = SDIG * 4;
    localparam int KDIG = (KEY_BITS + 1) / 4;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_KEY  = 4'b0010,
        F_STEP = 4'b0100,
        F_OUT  = 4'b1000
    } t_fstate;

    // One radix-16 digit of a residue: r*16 + d, then four conditional subtracts.
    function automatic logic [HW-1:0] red_t(input logic [HW-1:0] r, input logic [3:0] d);
        logic [HW+3:0] x;
        x = {r, d};
        for (int j = 3; j >= 0; j--) begin
            if (x >= ((HW+4)'(SLOT_COUNT) << j)) begin
                x = x - ((HW+4)'(SLOT_COUNT) << j);
            end
        end
        return x[HW-1:0];
    endfunction

    function automatic logic [PW-1:0] red_p(input logic [PW-1:0] r, input logic [3:0] d);
        logic [PW+3:0] x;
        x = {r, d};
        for (int j = 3; j >= 0; j--) begin
            if (x >= ((PW+4)'(STEP_PRIME) << j)) begin
                x = x - ((PW+4)'(STEP_PRIME) << j);
            end
        end
        return x[PW-1:0];
    endfunction

    t_fstate             r_state, n_state;
    t_in_item            r_item, n_item;
    logic [KDIG*4-1:0]   r_sh, n_sh;
    logic [SDW-1:0]      r_sv, n_sv;
    logic [HW-1:0]       r_rt, n_rt;
    logic [HW-1:0]       r_st, n_st;
    logic [PW-1:0]       r_rp, n_rp;
    logic [2:0]          r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_sh    = r_sh;
        n_sv    = r_sv;
        n_rt    = r_rt;
        n_st    = r_st;
        n_rp    = r_rp;
        n_cnt   = r_cnt;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_item  = i_item;
                    n_sh    = (KDIG*4)'(i_item.key);
                    n_rt    = '0;
                    n_rp    = '0;
                    n_st    = '0;
                    n_cnt   = '0;
                    n_state = F_KEY;
                end
            end
            F_KEY: begin
                n_rt  = red_t(r_rt, r_sh[KDIG*4-1 -: 4]);
                n_rp  = red_p(r_rp, r_sh[KDIG*4-1 -: 4]);
                n_sh  = r_sh << 4;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'(KDIG - 1)) begin
                    // The step is STEP_PRIME minus the key residue, never zero.
                    n_sv    = SDW'(STEP_PRIME) - SDW'(n_rp);
                    n_cnt   = '0;
                    n_state = F_STEP;
                end
            end
            F_STEP: begin
                n_st  = red_t(r_st, r_sv[SDW-1 -: 4]);
                n_sv  = r_sv << 4;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'(SDIG - 1)) begin
                    n_state = F_OUT;
                end
            end
            F_OUT: begin
                if (i_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item <= n_item;
        r_sh   <= n_sh;
        r_sv   <= n_sv;
        r_rt   <= n_rt;
        r_st   <= n_st;
        r_rp   <= n_rp;
        r_cnt  <= n_cnt;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_valid = (r_state == F_OUT);
    assign o_item  = r_item;
    assign o_home  = r_rt;
    assign o_step  = r_st;

endmodule

/* rtl/dht_back.sv */
// Back end: walks the probe sequence over the slot store and builds results.
module dht_back #(
    parameter int SLOT_COUNT = 101,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_qvalid,
    output logic                          o_qpop,
    input  dht_pkg::t_in_item             i_item,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_home,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_step,
    output logic                          o_rvalid,
    output dht_pkg::t_out_item            o_result,
    input  logic                          i_rready,
    output logic                          o_clearing
);

    import dht_pkg::*;

    localparam int HW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int VW = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
    localparam int RW = 1 + KEY_BITS + VW;

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_READ  = 5'b00100,
        B_CHECK = 5'b01000,
        B_DONE  = 5'b10000
    } t_bstate;

    t_bstate                r_state, n_state;
    logic [HW-1:0]          r_pos, n_pos;
    logic [HW-1:0]          r_step, n_step;
    logic [CW-1:0]          r_probe, n_probe;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_op, n_op;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [VW-1:0]          r_val, n_val;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic [DATA_BITS-1:0]   r_fv, n_fv;

    logic                   we;
    logic [RW-1:0]          wdata;
    logic [RW-1:0]          rdata;
    logic                   rd_used;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VW-1:0]          rd_val;
    logic [HW:0]            pos_sum;
    logic [HW-1:0]          pos_next;

    dht_ram #(
        .WIDTH (RW),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pos),
        .i_wdata (wdata),
        .i_raddr (r_pos),
        .o_rdata (rdata)
    );

    assign rd_used = rdata[RW-1];
    assign rd_key  = rdata[RW-2 -: KEY_BITS];
    assign rd_val  = rdata[VW-1:0];

    // Both operands stay below SLOT_COUNT, so one subtract wraps the sum.
    assign pos_sum  = {1'b0, r_pos} + {1'b0, r_step};
    assign pos_next = (pos_sum >= (HW+1)'(SLOT_COUNT)) ?
                      HW'(pos_sum - (HW+1)'(SLOT_COUNT)) : HW'(pos_sum);

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_step   = r_step;
        n_probe  = r_probe;
        n_count  = r_count;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_status = r_status;
        n_fv     = r_fv;
        we       = 1'b0;
        wdata    = '0;
        o_qpop   = 1'b0;
        o_rvalid = 1'b0;
        case (r_state)
            B_CLEAR: begin
                we = 1'b1;
                if (r_pos == HW'(SLOT_COUNT - 1)) begin
                    n_pos   = '0;
                    n_state = B_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            B_IDLE: begin
                if (i_qvalid) begin
                    o_qpop  = 1'b1;
                    n_op    = i_item.operation;
                    n_key   = i_item.key;
                    n_val   = i_item.value[VW-1:0];
                    n_pos   = i_home;
                    n_step  = i_step;
                    n_probe = '0;
                    n_fv    = '0;
                    if (i_item.operation == OP_INSERT && r_count == CW'(SLOT_COUNT)) begin
                        n_status = ST_FULL;
                        n_state  = B_DONE;
                    end else begin
                        n_state = B_READ;
                    end
                end
            end
            B_READ: begin
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (rd_used && rd_key == r_key) begin
                    if (r_op == OP_INSERT) begin
                        we       = 1'b1;
                        wdata    = {1'b1, r_key, r_val};
                        n_status = ST_UPDATED;
                    end else begin
                        n_status = ST_FOUND;
                        n_fv     = DATA_BITS'(rd_val);
                    end
                    n_state = B_DONE;
                end else if (!rd_used) begin
                    if (r_op == OP_INSERT) begin
                        we       = 1'b1;
                        wdata    = {1'b1, r_key, r_val};
                        n_count  = r_count + 1'b1;
                        n_status = ST_INSERTED;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    n_state = B_DONE;
                end else if (r_probe == CW'(SLOT_COUNT - 1)) begin
                    n_status = (r_op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    n_state  = B_DONE;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_pos   = pos_next;
                    n_state = B_READ;
                end
            end
            B_DONE: begin
                o_rvalid = 1'b1;
                if (i_rready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
        r_step   <= n_step;
        r_probe  <= n_probe;
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_status <= n_status;
        r_fv     <= n_fv;
    end

    assign o_result   = '{status: r_status, found_value: r_fv};
    assign o_clearing = (r_state == B_CLEAR);

endmodule

/* rtl/dht_checker.sv */
// Port level assertions for the double hashing table unit, bound to its top level.
module dht_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input dht_pkg::t_out_item o_result
);

    import dht_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && full)
        else $error("queues not empty and blocked after reset");

    a_clear_pass: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> full)
        else $error("input accepted before the slot clearing pass");

    a_value_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_FOUND) |-> (o_result.found_value == '0))
        else $error("found_value nonzero on a result that is not found");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind double_hash_table_unit dht_checker u_dht_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

/* tb/tb_double_hash_table_unit.sv */
// Self-checking testbench for the double hashing key/value table unit.
`timescale 1ns / 100ps

module tb_double_hash_table_unit;

    import dht_pkg::*;

    // Table geometry used for both the block and the predictor.
    localparam int TABLE_SLOTS = 101;
    localparam int STEP_MOD    = 97;
    // Keys that differ by this stride share both the home slot and the step, so they
    // line up on one probe chain.
    localparam int CHAIN_STRIDE = TABLE_SLOTS * STEP_MOD;
    // A result can take the key reduction plus one probe pass over every slot.
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam int FULL_ITEMS   = 100;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 200;
    localparam int PRINT_LIMIT  = 30;

    typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE} t_drain_mode;

    // Scoreboard: keeps its own copy of the table, predicts the result of every accepted
    // transaction and compares the results in order.
    class dht_scoreboard;
        int unsigned          slots;
        int unsigned          step_mod;
        bit                   slot_used[];
        logic [KEY_BITS-1:0]  slot_key[];
        logic [DATA_BITS-1:0] slot_value[];
        int unsigned          entries;
        t_out_item            pending_results[$];
        int unsigned          status_tally[8];
        int unsigned          accepted;
        int unsigned          checked;
        int unsigned          mismatches;

        function new(int unsigned table_slots, int unsigned step_prime);
            slots      = table_slots;
            step_mod   = step_prime;
            slot_used  = new[table_slots];
            slot_key   = new[table_slots];
            slot_value = new[table_slots];
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            entries    = 0;
            accepted   = 0;
            checked    = 0;
            mismatches = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        // Walks the double hashing probe sequence and updates the table copy.
        function t_out_item apply_table_op(t_in_item it);
            t_out_item   res;
            int unsigned pos;
            int unsigned stride;
            res.status      = (it.operation == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            res.found_value = '0;
            if (it.operation == OP_INSERT && entries >= slots) begin
                return res;
            end
            pos    = it.key % slots;
            stride = (step_mod - (it.key % step_mod)) % slots;
            for (int probe = 0; probe < slots; probe++) begin
                if (slot_used[pos] && slot_key[pos] == it.key) begin
                    if (it.operation == OP_INSERT) begin
                        slot_value[pos] = it.value;
                        res.status      = ST_UPDATED;
                    end else begin
                        res.status      = ST_FOUND;
                        res.found_value = slot_value[pos];
                    end
                    return res;
                end
                if (!slot_used[pos]) begin
                    if (it.operation == OP_INSERT) begin
                        slot_used[pos]  = 1'b1;
                        slot_key[pos]   = it.key;
                        slot_value[pos] = it.value;
                        entries++;
                        res.status      = ST_INSERTED;
                    end
                    return res;
                end
                pos = (pos + stride) % slots;
            end
            return res;
        endfunction

        function void note_input(t_in_item it);
            t_out_item want;
            want = apply_table_op(it);
            status_tally[want.status]++;
            accepted++;
            pending_results = {pending_results, want};
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_LIMIT) begin
                $display("[%0t] MISMATCH: %s", $time, what);
            end
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: status %0d value %h",
                                          got.status, got.found_value));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status) begin
                report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                          checked, got.status, want.status));
            end
            if (got.found_value !== want.found_value) begin
                report_mismatch($sformatf("result %0d found_value %h, expected %h",
                                          checked, got.found_value, want.found_value));
            end
        endtask
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    dht_scoreboard        sb;
    logic [KEY_BITS-1:0]  key_pool[$];
    int unsigned          burst_left;

    double_hash_table_unit #(
        .SLOT_COUNT (TABLE_SLOTS),
        .STEP_PRIME (STEP_MOD),
        .VALUE_BITS (DATA_BITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // 12 ns clock: 6 ns low, 6 ns high.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Safety net: far beyond the slowest correct run, where every transaction walks the
    // whole table, the receiver stalls as long as it ever does and the sender idles.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $display("Timed out with %0d results still expected", sb.pending_results.size());
        $finish;
    end

    function automatic logic [DATA_BITS-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key();
        return KEY_BITS'($urandom() >> 1);
    endfunction

    function automatic logic [KEY_BITS-1:0] pool_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    // The pool mixes long chains (keys sharing home and step), keys sharing only the home
    // slot, and scattered keys, so that searches and updates hit stored entries often.
    task automatic build_key_pool();
        logic [KEY_BITS-1:0] base;
        for (int f = 0; f < 6; f++) begin
            base = KEY_BITS'($urandom_range(0, 32'h7FFF_FFFF - 6 * CHAIN_STRIDE));
            for (int j = 0; j < 5; j++) begin
                key_pool = {key_pool, KEY_BITS'(base + j * CHAIN_STRIDE)};
            end
            for (int j = 1; j < 4; j++) begin
                key_pool = {key_pool, KEY_BITS'(base + j * TABLE_SLOTS)};
            end
        end
        repeat (22) key_pool = {key_pool, rand_key()};
    endtask

    // Offers one transaction at the falling edge and holds it until the block takes it at a
    // rising edge with full low. While push is low the payload carries junk on purpose.
    task automatic offer(logic op, logic [KEY_BITS-1:0] key, logic [DATA_BITS-1:0] value);
        t_in_item it;
        it.operation = op;
        it.key       = key;
        it.value     = value;
        @(negedge i_clk);
        push   = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (full);
        sb.note_input(it);
        // Bursts of random length; some are long so that stretches without gaps occur.
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge i_clk);
                push   = 1'b0;
                i_item = {$urandom(), $urandom()};
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    // Result side: every accepted result goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_result);
        end
    end

    // Receiver stall pattern. The mode is redrawn at random as the run goes on; once, after HOLD_AFTER
    // results, it holds pop low for a long stretch so the block backs up and raises full.
    initial begin : receiver
        t_drain_mode mode;
        int unsigned cycle_count;
        int unsigned hold_left;
        bit          held;
        mode        = DRAIN_FREE;
        cycle_count = 0;
        hold_left   = 0;
        held        = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            cycle_count++;
            if (cycle_count % 64 == 0) begin
                mode = t_drain_mode'($urandom_range(0, 2));
            end
            if (!held && sb.checked >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop = 1'b0;
            end else begin
                case (mode)
                    DRAIN_FREE:   pop = 1'b1;
                    DRAIN_COIN:   pop = 1'($urandom_range(0, 1));
                    DRAIN_SPARSE: pop = (cycle_count % 4 == 0);
                    default:      pop = 1'b1;
                endcase
            end
        end
    end

    initial begin : stimulus
        logic op;
        logic [KEY_BITS-1:0] key;
        sb         = new(TABLE_SLOTS, STEP_MOD);
        burst_left = 4;
        build_key_pool();

        // Synchronous reset is held, then released at a falling edge; the block then clears its store
        // with full high, which the handshake in offer simply waits out.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty-table search, key and value extremes, updates, and probe chains
        // where keys collide on the home slot alone or on both home slot and step.
        offer(OP_SEARCH, '0, '1);
        offer(OP_INSERT, '0, '0);
        offer(OP_INSERT, '1, '1);
        offer(OP_SEARCH, '0, 32'h1234_5678);
        offer(OP_SEARCH, '1, '0);
        offer(OP_INSERT, '0, '1);
        offer(OP_SEARCH, '0, '0);
        offer(OP_INSERT, KEY_BITS'(TABLE_SLOTS), 32'h0F0F_0F0F);
        offer(OP_INSERT, KEY_BITS'(CHAIN_STRIDE), 32'hF0F0_F0F0);
        offer(OP_INSERT, KEY_BITS'(2 * CHAIN_STRIDE), 32'hDEAD_BEEF);
        offer(OP_SEARCH, KEY_BITS'(2 * CHAIN_STRIDE), '0);
        offer(OP_SEARCH, KEY_BITS'(3 * CHAIN_STRIDE), '0);
        offer(OP_INSERT, KEY_BITS'(STEP_MOD - 1), 32'hA5A5_A5A5);
        offer(OP_INSERT, KEY_BITS'(STEP_MOD), 32'h5A5A_5A5A);
        offer(OP_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
        offer(OP_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
        offer(OP_SEARCH, 31'h2AAA_AAAA, '1);
        offer(OP_SEARCH, 31'h5555_5555, '0);
        offer(OP_INSERT, KEY_BITS'(2 * CHAIN_STRIDE), 32'h8000_0001);
        offer(OP_SEARCH, KEY_BITS'(2 * CHAIN_STRIDE), '0);
        offer(OP_SEARCH, KEY_BITS'(CHAIN_STRIDE), '0);
        offer(OP_SEARCH, KEY_BITS'(TABLE_SLOTS), '0);

        // Random part: mostly pool keys so that updates, hits and deep chains dominate.
        // Fresh keys are inserted only while the table is lightly loaded, so it stays below
        // full here and the filling happens later on purpose.
        repeat (RANDOM_ITEMS) begin
            op = $urandom_range(0, 1) ? OP_SEARCH : OP_INSERT;
            if (op == OP_INSERT) begin
                key = ($urandom_range(0, 9) == 0 && sb.entries < 30) ? rand_key() : pool_key();
            end else begin
                key = $urandom_range(0, 1) ? pool_key() : rand_key();
            end
            offer(op, key, rand_value());
        end

        // Fill the table completely.
        while (sb.entries < TABLE_SLOTS) begin
            offer(OP_INSERT, rand_key(), rand_value());
        end

        // Full table: inserts are refused even for stored keys, and searches for missing keys
        // walk every slot before they give up.
        repeat (FULL_ITEMS) begin
            case ($urandom_range(0, 4))
                0, 1: offer(OP_INSERT, pool_key(), rand_value());
                2:    offer(OP_INSERT, rand_key(), rand_value());
                3:    offer(OP_SEARCH, pool_key(), rand_value());
                default: offer(OP_SEARCH, rand_key(), rand_value());
            endcase
        end

        @(negedge i_clk);
        push = 1'b0;

        // Let every expected result drain, then watch for stray ones.
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transactions in and %0d results out; table held %0d of %0d",
                 sb.accepted, sb.checked, sb.entries, TABLE_SLOTS);
        $display("Outcomes: %0d inserted, %0d updated, %0d refused, %0d hits, %0d misses",
                 sb.status_tally[ST_INSERTED], sb.status_tally[ST_UPDATED],
                 sb.status_tally[ST_FULL], sb.status_tally[ST_FOUND],
                 sb.status_tally[ST_NOT_FOUND]);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
